>>> rtl/cbts_pkg.sv
// cbts_pkg: shared constants and types for the can fd bit timing solver
// used by cbts_ctrl, cbts_dpath and canfd_bit_timing_solver_unit
package cbts_pkg;

    localparam int MAX_PRESCALER_DEF = 256;

    localparam int CLK_W  = 32;
    localparam int PCT_W  = 8;
    // quotient of a 32-bit clock over a divisor of at least one
    localparam int TOT_W  = 32;

    // phase limits
    localparam logic [8:0] NOM_T1_MIN  = 9'd2;
    localparam logic [8:0] NOM_T1_MAX  = 9'd256;
    localparam logic [8:0] NOM_T2_MIN  = 9'd1;
    localparam logic [8:0] NOM_T2_MAX  = 9'd128;
    localparam logic [8:0] NOM_SJW_MAX = 9'd128;
    localparam logic [8:0] DAT_T1_MIN  = 9'd1;
    localparam logic [8:0] DAT_T1_MAX  = 9'd32;
    localparam logic [8:0] DAT_T2_MIN  = 9'd1;
    localparam logic [8:0] DAT_T2_MAX  = 9'd16;
    localparam logic [8:0] DAT_SJW_MAX = 9'd16;

    localparam logic [6:0] ROUND_HALF  = 7'd50;
    localparam logic [6:0] PCT_FULL    = 7'd100;
    localparam logic [2:0] MIN_QUANTA  = 3'd4;
    localparam logic [6:0] OFFSET_MAX  = 7'h7F;
    localparam logic [1:0] TDC_AUTO    = 2'd2;

    // controller commands to the datapath
    typedef struct packed {
        logic load;       // capture request, clear results
        logic phase_sel;  // 0 nominal, 1 data
        logic trial_init; // brp <= 1 for this phase
        logic mul_go;     // form divisor = rate * brp
        logic div_start;  // start clock / divisor
        logic eval;       // form rounding numerator from quotient
        logic brp_inc;    // next prescaler
        logic commit;     // latch phase result
        logic finish;     // form delay comp word
    } cbts_cmd_t;

    typedef struct packed {
        logic pct_bad;
        logic rate_zero;
        logic div_busy;
        logic exact;      // remainder zero
        logic few;        // quotient below four
        logic fits;       // tseg limits met
        logic brp_last;   // brp equals max prescaler
    } cbts_sts_t;

endpackage

>>> rtl/cbts_div.sv
// cbts_div: restoring divider, one quotient bit per cycle
// depends on cbts_pkg
module cbts_div
    import cbts_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [CLK_W-1:0] dividend,
    input  logic [40:0]      divisor,
    output logic             busy,
    output logic [CLK_W-1:0] quot,
    output logic [40:0]      rem
);
    logic [5:0]       cnt_reg, cnt_next;
    logic [CLK_W-1:0] q_reg, q_next;
    logic [41:0]      r_reg, r_next;
    logic [41:0]      shifted, diff;

    always_comb begin
        shifted = {r_reg[40:0], q_reg[CLK_W-1]};
        diff    = shifted - {1'b0, divisor};
        cnt_next = cnt_reg;
        q_next   = q_reg;
        r_next   = r_reg;
        if (start) begin
            cnt_next = 6'(CLK_W);
            q_next   = dividend;
            r_next   = '0;
        end else if (cnt_reg != 6'd0) begin
            cnt_next = cnt_reg - 6'd1;
            if (!diff[41]) begin
                r_next = diff;
                q_next = {q_reg[CLK_W-2:0], 1'b1};
            end else begin
                r_next = shifted;
                q_next = {q_reg[CLK_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign busy = (cnt_reg != 6'd0);
    assign quot = q_reg;
    assign rem  = r_reg[40:0];
endmodule

>>> rtl/cbts_dpath.sv
// cbts_dpath: operand registers, prescaler, divider and timing field math
// depends on cbts_pkg and cbts_div
module cbts_dpath
    import cbts_pkg::*;
#(
    parameter int MAX_PRESCALER = MAX_PRESCALER_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cbts_cmd_t        cmd,
    output cbts_sts_t        sts,
    input  logic [CLK_W-1:0] clock_hz,
    input  logic [CLK_W-1:0] nominal_rate,
    input  logic [CLK_W-1:0] data_rate,
    input  logic [PCT_W-1:0] sample_percent,
    output logic [31:0]      nominal_word,
    output logic [31:0]      data_word,
    output logic [31:0]      delay_comp_word
);
    localparam int BRP_W = $clog2(MAX_PRESCALER + 1);

    logic [CLK_W-1:0] clk_reg, nr_reg, dr_reg;
    logic [PCT_W-1:0] pct_reg;
    logic [BRP_W-1:0] brp_reg;
    logic [40:0]      divisor_reg;
    logic [31:0]      nw_reg, dw_reg, dcw_reg;
    logic [8:0]       t1d_reg;
    logic [8:0]       brpd_reg;
    logic [31:0]      word_reg;
    logic [8:0]       t1_reg;
    logic             fits_reg;
    logic [39:0]      rnum_reg;
    logic [CLK_W-1:0] quot;
    logic [40:0]      rem;
    logic             div_busy;
    logic [CLK_W-1:0] rate;

    assign rate = cmd.phase_sel ? dr_reg : nr_reg;

    cbts_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (clk_reg),
        .divisor  (divisor_reg),
        .busy     (div_busy),
        .quot     (quot),
        .rem      (rem)
    );

    // r = (total*pct+50)/100 ; any r above 257 fails the tseg1 limit, so only a
    // numerator below 25800 needs the exact quotient
    localparam logic [39:0] R_NUM_LIMIT = 40'd25800;
    localparam logic [12:0] RECIP_100   = 13'd5243;  // ceil(2^19 / 100)
    logic [39:0] rprod;
    assign rprod = 40'(quot) * 40'(pct_reg);

    // ev cycle registers the numerator, next cycle divides by 100
    logic        r_big;
    logic [27:0] r_mul;
    logic [33:0] r_val;
    always_comb begin
        r_big = (rnum_reg >= R_NUM_LIMIT);
        r_mul = 28'(rnum_reg[14:0]) * 28'(RECIP_100);
        r_val = 34'(r_mul[27:19]);
    end

    logic [8:0] t1_min, t1_max, t2_min, t2_max, sjw_max;
    assign t1_min  = cmd.phase_sel ? DAT_T1_MIN  : NOM_T1_MIN;
    assign t1_max  = cmd.phase_sel ? DAT_T1_MAX  : NOM_T1_MAX;
    assign t2_min  = cmd.phase_sel ? DAT_T2_MIN  : NOM_T2_MIN;
    assign t2_max  = cmd.phase_sel ? DAT_T2_MAX  : NOM_T2_MAX;
    assign sjw_max = cmd.phase_sel ? DAT_SJW_MAX : NOM_SJW_MAX;

    logic [33:0] t1w;
    logic [33:0] t2w;
    logic        ok;
    logic [8:0]  sjw;
    always_comb begin
        t1w = r_val - 34'd1;
        t2w = 34'(quot) - 34'd1 - t1w;
        ok  = !r_big && (r_val != 34'd0)
            && (t1w >= 34'(t1_min)) && (t1w <= 34'(t1_max))
            && (34'(quot) >= 34'd1 + t1w + 34'(t2_min))
            && (t2w <= 34'(t2_max));
        sjw = (t2w[8:0] < sjw_max) ? t2w[8:0] : sjw_max;
    end

    logic [15:0] off_full;
    assign off_full = 16'(brpd_reg) * 16'(t1d_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            clk_reg <= clock_hz;
            nr_reg  <= nominal_rate;
            dr_reg  <= data_rate;
            pct_reg <= sample_percent;
            nw_reg  <= '0;
            dw_reg  <= '0;
            dcw_reg <= '0;
        end
        if (cmd.trial_init) brp_reg <= BRP_W'(1);
        else if (cmd.brp_inc) brp_reg <= brp_reg + BRP_W'(1);
        if (cmd.mul_go) divisor_reg <= 41'(rate) * 41'(brp_reg);
        if (cmd.eval) rnum_reg <= rprod + 40'(ROUND_HALF);
        // second eval cycle registers fit result
        fits_reg <= ok;
        word_reg <= {8'(brp_reg - BRP_W'(1)), 8'(t1w - 34'd1), 8'(t2w - 34'd1),
                     8'(sjw - 9'd1)};
        t1_reg   <= t1w[8:0];
        if (cmd.commit) begin
            if (cmd.phase_sel) begin
                dw_reg   <= word_reg;
                t1d_reg  <= t1_reg;
                brpd_reg <= 9'(brp_reg);
            end else begin
                nw_reg <= word_reg;
            end
        end
        if (cmd.finish)
            dcw_reg <= {14'd0, TDC_AUTO, 1'b0,
                        (off_full > 16'(OFFSET_MAX)) ? OFFSET_MAX : off_full[6:0], 8'd0};
    end

    assign sts.pct_bad   = (pct_reg == '0) || (pct_reg >= PCT_W'(PCT_FULL));
    assign sts.rate_zero = (rate == '0);
    assign sts.div_busy  = div_busy;
    assign sts.exact     = (rem == '0);
    assign sts.few       = (quot < 32'(MIN_QUANTA));
    assign sts.fits      = fits_reg;
    assign sts.brp_last  = (brp_reg == BRP_W'(MAX_PRESCALER));

    assign nominal_word    = nw_reg;
    assign data_word       = dw_reg;
    assign delay_comp_word = dcw_reg;
endmodule

>>> rtl/cbts_ctrl.sv
// cbts_ctrl: sequencer over phases and prescaler trials
// depends on cbts_pkg
module cbts_ctrl
    import cbts_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      start,
    input  logic      out_taken,
    output logic      idle,
    output logic      out_valid,
    output logic      err,
    output cbts_cmd_t cmd,
    input  cbts_sts_t sts
);
    localparam logic [3:0] S_IDLE = 4'd0, S_CHK = 4'd1, S_INIT = 4'd2, S_MUL = 4'd3,
                           S_DIV = 4'd4, S_WAIT = 4'd5, S_TEST = 4'd6, S_EV2 = 4'd7,
                           S_EV3 = 4'd8, S_NEXT = 4'd9, S_FIN = 4'd10, S_OUT = 4'd11,
                           S_FAIL = 4'd12;

    logic [3:0] state_reg, state_next;
    logic       ph_reg, ph_next, err_reg, err_next;

    always_comb begin
        state_next = state_reg;
        ph_next    = ph_reg;
        err_next   = err_reg;
        cmd        = '0;
        cmd.phase_sel = ph_reg;
        unique case (state_reg)
            S_IDLE: if (start) begin
                cmd.load = 1'b1; ph_next = 1'b0; err_next = 1'b0; state_next = S_CHK;
            end
            S_CHK: state_next = sts.pct_bad ? S_FAIL : S_INIT;
            S_INIT: begin
                cmd.trial_init = 1'b1;
                state_next = sts.rate_zero ? S_FAIL : S_MUL;
            end
            S_MUL: begin cmd.mul_go = 1'b1; state_next = S_DIV; end
            S_DIV: begin cmd.div_start = 1'b1; state_next = S_WAIT; end
            S_WAIT: if (!sts.div_busy) state_next = S_TEST;
            S_TEST: begin
                if (!sts.exact) state_next = S_NEXT;
                else if (sts.few) state_next = S_FAIL;
                else begin cmd.eval = 1'b1; state_next = S_EV2; end
            end
            S_EV2: state_next = S_EV3;   // fit terms register
            S_EV3: begin
                if (sts.fits) begin
                    cmd.commit = 1'b1;
                    if (ph_reg) state_next = S_FIN;
                    else begin ph_next = 1'b1; state_next = S_INIT; end
                end else state_next = S_NEXT;
            end
            S_NEXT: begin
                if (sts.brp_last) state_next = S_FAIL;
                else begin cmd.brp_inc = 1'b1; state_next = S_MUL; end
            end
            S_FIN: begin cmd.finish = 1'b1; state_next = S_OUT; end
            S_FAIL: begin err_next = 1'b1; cmd.load = 1'b0; state_next = S_OUT; end
            S_OUT: if (out_taken) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ph_reg    <= 1'b0;
            err_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
            err_reg   <= err_next;
        end
    end

    assign idle      = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign err       = err_reg;
endmodule

>>> rtl/canfd_bit_timing_solver_unit.sv
// channel  dir  tdata fields (low bit up)                         tuser
// s_axis   in   clock_hz, nominal_rate, data_rate, sample_percent  -
// m_axis   out  nominal_word, data_word, delay_comp_word           status
// one request at a time; each prescaler trial runs the divider once, and a request
// tries up to MAX_PRESCALER prescalers in each of its two phases
// reset clears the sequencer; the result is held until m_tready
// top level, depends on cbts_pkg, cbts_ctrl, cbts_dpath
module canfd_bit_timing_solver_unit
    import cbts_pkg::*;
#(
    parameter int MAX_PRESCALER = MAX_PRESCALER_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,  // clock_hz, nominal_rate, data_rate, sample_percent
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,  // nominal_word, data_word, delay_comp_word
    output logic         m_tuser   // status
);
    cbts_cmd_t cmd;
    cbts_sts_t sts;
    logic idle, err;
    logic [31:0] nw, dw, dcw;

    cbts_ctrl u_ctrl (
        .aclk (aclk), .aresetn (aresetn), .start (s_tvalid), .out_taken (m_tready),
        .idle (idle), .out_valid (m_tvalid), .err (err), .cmd (cmd), .sts (sts)
    );

    cbts_dpath #(.MAX_PRESCALER (MAX_PRESCALER)) u_dpath (
        .aclk (aclk), .aresetn (aresetn), .cmd (cmd), .sts (sts),
        .clock_hz (s_tdata[31:0]), .nominal_rate (s_tdata[63:32]),
        .data_rate (s_tdata[95:64]), .sample_percent (s_tdata[103:96]),
        .nominal_word (nw), .data_word (dw), .delay_comp_word (dcw)
    );

    assign s_tready = idle;
    // error result reads as zero words
    assign m_tdata  = err ? 96'd0 : {dcw, dw, nw};
    assign m_tuser  = err;
endmodule

>>> sim/cbts_checker.sv
// cbts_checker: watches both channels of the bit timing solver and predicts each result
// depends on cbts_pkg for the phase limits and rounding constants
`timescale 1ns / 100ps

module cbts_checker
    import cbts_pkg::*;
#(
    parameter int MAX_PRESCALER = MAX_PRESCALER_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [103:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [95:0]  m_tdata,
    input  logic         m_tuser,
    output int           errors,
    output int           pending
);

    typedef struct packed {
        logic        status;
        logic [31:0] nominal_word;
        logic [31:0] data_word;
        logic [31:0] delay_comp_word;
    } timing_t;

    timing_t timing_q[$];

    // search one phase; returns 1 when a prescaler fits
    function automatic bit search_phase(input logic [63:0] clk, input logic [63:0] rate,
                                        input logic [63:0] pct, input bit data_phase,
                                        output logic [31:0] word, output logic [63:0] t1_o,
                                        output logic [63:0] brp_o);
        logic [63:0] t1_min, t1_max, t2_min, t2_max, sjw_max;
        logic [63:0] dv, total, r, t1, t2, sjw;
        word = '0;
        t1_o = '0;
        brp_o = '0;
        t1_min  = 64'(data_phase ? DAT_T1_MIN  : NOM_T1_MIN);
        t1_max  = 64'(data_phase ? DAT_T1_MAX  : NOM_T1_MAX);
        t2_min  = 64'(data_phase ? DAT_T2_MIN  : NOM_T2_MIN);
        t2_max  = 64'(data_phase ? DAT_T2_MAX  : NOM_T2_MAX);
        sjw_max = 64'(data_phase ? DAT_SJW_MAX : NOM_SJW_MAX);
        if (rate == 0) return 0;
        for (logic [63:0] brp = 1; brp <= MAX_PRESCALER; brp++) begin
            dv = rate * brp;
            if (clk % dv != 0) continue;
            total = clk / dv;
            if (total < 64'(MIN_QUANTA)) return 0;
            r = (total * pct + 64'(ROUND_HALF)) / 64'(PCT_FULL);
            if (r < 1) continue;
            t1 = r - 1;
            if (t1 < t1_min || t1 > t1_max) continue;
            if (total < 1 + t1 + t2_min) continue;
            t2 = total - 1 - t1;
            if (t2 < t2_min || t2 > t2_max) continue;
            sjw = (t2 < sjw_max) ? t2 : sjw_max;
            word = {8'(brp - 1), 8'(t1 - 1), 8'(t2 - 1), 8'(sjw - 1)};
            t1_o = t1;
            brp_o = brp;
            return 1;
        end
        return 0;
    endfunction

    function automatic timing_t solve_timing(input logic [103:0] req);
        timing_t     res;
        logic [63:0] clk, nr, dr, pct, t1n, brpn, t1d, brpd, off;
        logic [31:0] nw, dw;
        clk = 64'(req[31:0]);
        nr  = 64'(req[63:32]);
        dr  = 64'(req[95:64]);
        pct = 64'(req[103:96]);
        res = '0;
        res.status = 1'b1;
        if (pct == 0 || pct >= 64'(PCT_FULL)) return res;
        if (!search_phase(clk, nr, pct, 1'b0, nw, t1n, brpn)) return res;
        if (!search_phase(clk, dr, pct, 1'b1, dw, t1d, brpd)) return res;
        off = brpd * t1d;
        if (off > 64'(OFFSET_MAX)) off = 64'(OFFSET_MAX);
        res.status = 1'b0;
        res.nominal_word = nw;
        res.data_word = dw;
        res.delay_comp_word = (32'(TDC_AUTO) << 16) | (32'(off) << 8);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch %s: got %h, expected %h", $realtime, what, got, want);
        errors++;
    endtask

    initial errors = 0;
    assign pending = timing_q.size();

    always @(posedge aclk) begin
        timing_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) timing_q.push_back(solve_timing(s_tdata));
            if (m_tvalid && m_tready) begin
                if (timing_q.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata[31:0], '0);
                end else begin
                    want = timing_q.pop_front();
                    if (m_tuser !== want.status)
                        report_mismatch("status", 32'(m_tuser), 32'(want.status));
                    if (m_tdata[31:0] !== want.nominal_word)
                        report_mismatch("nominal_word", m_tdata[31:0], want.nominal_word);
                    if (m_tdata[63:32] !== want.data_word)
                        report_mismatch("data_word", m_tdata[63:32], want.data_word);
                    if (m_tdata[95:64] !== want.delay_comp_word)
                        report_mismatch("delay_comp_word", m_tdata[95:64],
                                        want.delay_comp_word);
                end
            end
        end
    end

endmodule

>>> sim/tb_canfd_bit_timing_solver_unit.sv
// tb_canfd_bit_timing_solver_unit: drives timing requests into the solver and gives the verdict
// depends on cbts_pkg, canfd_bit_timing_solver_unit and cbts_checker
`timescale 1ns / 100ps

module tb_canfd_bit_timing_solver_unit;
    import cbts_pkg::*;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;   // clock_hz, nominal_rate, data_rate, sample_percent
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;   // nominal_word, data_word, delay_comp_word
    logic         m_tuser;   // status
    int           errors;
    int           pending;
    bit           hold_off;

    canfd_bit_timing_solver_unit dut (.*);

    cbts_checker checker_i (.*);

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 200);
    endfunction

    task automatic send_request(input logic [31:0] clk, input logic [31:0] nr,
                                input logic [31:0] dr, input logic [7:0] pct);
        int gap;
        s_tdata  <= {pct, dr, nr, clk};
        s_tvalid <= 1'b1;
        forever begin
            @(negedge aclk);
            if (s_tready) break;
        end
        @(posedge aclk);
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // clock built so that both phases divide exactly
    task automatic send_solvable();
        logic [31:0] nbrp, ntot, dbrp, dtot, mult, pct;
        nbrp = $urandom_range(1, 8);
        ntot = $urandom_range(4, 40);
        dbrp = $urandom_range(1, 8);
        dtot = $urandom_range(4, 25);
        mult = $urandom_range(1, 60000);
        pct  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 99) : $urandom_range(50, 90);
        send_request(nbrp * ntot * dbrp * dtot * mult, dbrp * dtot * mult,
                     nbrp * ntot * mult, pct[7:0]);
    endtask

    // receiver
    initial begin
        int roll;
        m_tready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (60000) @(posedge aclk);
                hold_off = 1'b0;
            end
            roll = $urandom_range(0, 99);
            if (roll < 60) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge aclk);
            end else begin
                m_tready <= 1'b0;
                repeat ((roll < 95) ? $urandom_range(1, 4) : $urandom_range(20, 300))
                    @(posedge aclk);
            end
        end
    end

    initial begin
        int roll;
        hold_off = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed
        send_request(32'd80_000_000, 32'd500_000, 32'd2_000_000, 8'd80);
        send_request(32'd80_000_000, 32'd500_000, 32'd2_000_000, 8'd0);
        send_request(32'd80_000_000, 32'd500_000, 32'd2_000_000, 8'd100);
        send_request(32'd80_000_000, 32'd500_000, 32'd2_000_000, 8'd255);
        send_request(32'd80_000_000, 32'd500_000, 32'd2_000_000, 8'd1);
        send_request(32'd80_000_000, 32'd500_000, 32'd2_000_000, 8'd99);
        send_request(32'd80_000_000, 32'd0, 32'd2_000_000, 8'd75);
        send_request(32'd80_000_000, 32'd500_000, 32'd0, 8'd75);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd50);
        send_request(32'd0, 32'd1, 32'd1, 8'd50);
        send_request(32'd3_000, 32'd1_000, 32'd1_000, 8'd50);      // too few quanta
        send_request(32'd40_000_000, 32'd1_000_000, 32'd10_000_000, 8'd1);
        send_request(32'd5_120, 32'd20, 32'd1, 8'd80);             // offset saturates
        send_request(32'd40_000_000, 32'd1_000_000, 32'd5_000_000, 8'd87);
        send_request(32'd60_000_000, 32'd250_000, 32'd4_000_000, 8'd70);
        send_request(32'd80_000_000, 32'd1_234_567, 32'd2_000_000, 8'd80);
        send_request(32'd1_024, 32'd1, 32'd1, 8'd50);              // nominal needs brp 4, data needs brp 32
        send_request(32'd80_000_000, 32'd125_000, 32'd8_000_000, 8'd60);

        // random; long receiver stall near the start
        for (int i = 0; i < 100; i++) begin
            if (i == 5) hold_off = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 75) begin
                send_solvable();
            end else if (roll < 90) begin
                send_request($urandom, $urandom, $urandom, 8'($urandom));
            end else begin
                send_request($urandom, $urandom_range(0, 2), $urandom_range(0, 2),
                             8'($urandom_range(0, 120)));
            end
        end
        s_tvalid <= 1'b0;

        // let the checker record the last request first
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (errors == 0) begin
            $display("tb_canfd_bit_timing_solver_unit: done, clean");
        end else begin
            $display("tb_canfd_bit_timing_solver_unit: done, errors");
        end
        $finish;
    end

    initial begin
        #400ms;
        $display("tb_canfd_bit_timing_solver_unit: done, errors");
        $finish;
    end

endmodule
